[rtl/disc_pair_collision_response_macros.svh]
// assertion macros shared by the disc pair collision response checkers
// no dependencies; included by the checker file
`ifndef DISC_PAIR_COLLISION_RESPONSE_MACROS_SVH
`define DISC_PAIR_COLLISION_RESPONSE_MACROS_SVH

// clocked check, off while reset is asserted
`define DPCR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also holds during reset
`define DPCR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dpcr_pkg.sv]
// shared types, stage counts and saturation helper for the disc pair pipeline
// no dependencies
`default_nettype none

package dpcr_pkg;

  localparam int unsigned NormBits    = 28;
  localparam int unsigned QuoBits     = NormBits + 1;
  localparam int unsigned RadW        = 64;
  localparam int unsigned RootW       = 32;
  localparam int unsigned SqrtStages  = RootW / 2;
  localparam int unsigned DivStages   = (QuoBits + 1) / 2;
  localparam int unsigned FrontStages = 3;
  localparam int unsigned ImpStages   = 7;
  localparam int unsigned Latency     = FrontStages + SqrtStages + DivStages + ImpStages;
  localparam int unsigned SatW        = 40;

  // lanes: 0 first x, 1 first y, 2 second x, 3 second y
  typedef struct packed {
    logic [3:0][31:0] pos;
    logic [3:0][31:0] vel;
    logic [32:0]      rvx;
    logic [32:0]      rvy;
    logic [31:0]      rsum;
    logic [31:0]      m1;
    logic [31:0]      m2;
    logic [32:0]      msum;
    logic [31:0]      ax;
    logic [31:0]      ay;
    logic             sx;
    logic             sy;
    logic             contact;
    logic [31:0]      ovl;
  } item_t;

  function automatic logic [31:0] sat32(input logic signed [SatW-1:0] v);
    logic [31:0] r;
    if (v[SatW-1:31] == '0 || v[SatW-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SatW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/dpcr_isqrt.sv]
// pipelined integer square root, two root digits per stage
// depends on dpcr_pkg
`default_nettype none

module dpcr_isqrt import dpcr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0] rem_q [SqrtStages];
  logic [RadW-1:0] res_q [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stg
    logic [RadW-1:0] rem_in, res_in, rem_t, res_t;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    always_comb begin
      logic [RadW-1:0] bitv;
      logic [RadW-1:0] trial;
      bitv  = '0;
      trial = '0;
      rem_t = rem_in;
      res_t = res_in;
      for (int j = 0; j < 2; j++) begin
        bitv  = RadW'(1) << (2 * (RootW - 1 - 2 * k - j));
        trial = res_t + bitv;
        if (rem_t >= trial) begin
          rem_t = rem_t - trial;
          res_t = (res_t >> 1) + bitv;
        end else begin
          res_t = res_t >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_t;
        res_q[k] <= res_t;
      end
    end
  end

  assign root_o = res_q[SqrtStages-1][RootW-1:0];

endmodule

`default_nettype wire

[rtl/dpcr_div.sv]
// pipelined restoring divider for quotients below 2^(NormBits+1), two bits per stage
// depends on dpcr_pkg
`default_nettype none

module dpcr_div import dpcr_pkg::*; #(
  parameter int unsigned DW = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [DW-1:0]      rem_i,
  input  logic               nbit_i,
  input  logic [DW-1:0]      den_i,
  output logic [QuoBits-1:0] quo_o
);

  logic [DW-1:0]      rem_q [DivStages];
  logic [DW-1:0]      den_q [DivStages];
  logic [QuoBits-1:0] quo_q [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stg
    logic [DW-1:0]      rem_in, den_in, rem_t;
    logic [QuoBits-1:0] quo_in, quo_t;
    logic               nb;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign nb     = nbit_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign nb     = 1'b0;
    end

    always_comb begin
      logic [DW:0] r2;
      r2    = '0;
      rem_t = rem_in;
      quo_t = quo_in;
      for (int j = 0; j < 2; j++) begin
        if (2 * k + j < QuoBits) begin
          r2 = {rem_t, (j == 0) ? nb : 1'b0};
          if (r2 >= {1'b0, den_in}) begin
            r2    = r2 - {1'b0, den_in};
            quo_t = {quo_t[QuoBits-2:0], 1'b1};
          end else begin
            quo_t = {quo_t[QuoBits-2:0], 1'b0};
          end
          rem_t = r2[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_t;
        den_q[k] <= den_in;
        quo_q[k] <= quo_t;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

`default_nettype wire

[rtl/dpcr_impulse.sv]
// back end: dot product, separation, elastic impulse, friction scale, saturation
// depends on dpcr_pkg
`default_nettype none

module dpcr_impulse import dpcr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  item_t              item_i,
  input  logic [QuoBits-1:0] nxm_i,
  input  logic [QuoBits-1:0] nym_i,
  input  logic [QuoBits-1:0] f1_i,
  input  logic [QuoBits-1:0] f2_i,
  input  logic [FRAC_BITS:0] gain_i,
  output logic [3:0][31:0]   pos_o,
  output logic [3:0][31:0]   vel_o,
  output logic               overlap_o,
  output logic               impulse_o
);

  localparam int unsigned PW   = 32 + QuoBits;
  localparam int unsigned DotW = 35;
  localparam int unsigned DMW  = 33;
  localparam int unsigned PrW  = DMW + QuoBits;
  localparam int unsigned KW   = PrW - NormBits + 1;
  localparam int unsigned KnW  = KW + QuoBits;
  localparam int unsigned TW   = KnW - NormBits;
  localparam int unsigned UW   = TW + 2;
  localparam int unsigned UMW  = UW - 1;
  localparam int unsigned UGW  = UMW + FRAC_BITS + 1;

  // stage 1: magnitude products for the dot terms and the separation
  logic [32:0] rvx_neg, rvy_neg;
  logic [31:0] rvxm, rvym;
  item_t              q1_it_q;
  logic [QuoBits-1:0] q1_nxm_q, q1_nym_q, q1_f1_q, q1_f2_q;
  logic [PW-1:0]      q1_pdx_q, q1_pdy_q, q1_psx_q, q1_psy_q;
  logic               q1_dsx_q, q1_dsy_q;

  assign rvx_neg = -item_i.rvx;
  assign rvy_neg = -item_i.rvy;
  assign rvxm    = item_i.rvx[32] ? rvx_neg[31:0] : item_i.rvx[31:0];
  assign rvym    = item_i.rvy[32] ? rvy_neg[31:0] : item_i.rvy[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_it_q  <= item_i;
      q1_nxm_q <= nxm_i;
      q1_nym_q <= nym_i;
      q1_f1_q  <= f1_i;
      q1_f2_q  <= f2_i;
      q1_pdx_q <= PW'(rvxm) * PW'(nxm_i);
      q1_pdy_q <= PW'(rvym) * PW'(nym_i);
      q1_psx_q <= PW'(item_i.ovl) * PW'(nxm_i);
      q1_psy_q <= PW'(item_i.ovl) * PW'(nym_i);
      q1_dsx_q <= item_i.rvx[32] ^ item_i.sx;
      q1_dsy_q <= item_i.rvy[32] ^ item_i.sy;
    end
  end

  // stage 2: dot sum, pushed-apart positions
  logic signed [DotW-1:0] txs, tys, dot_d;
  logic signed [33:0]     sepx, sepy;
  logic [3:0][31:0]       pos2_d;
  logic                   app_d;

  always_comb begin
    logic signed [33:0] np;
    np    = '0;
    txs   = q1_dsx_q ? -DotW'(q1_pdx_q[PW-1:NormBits]) : DotW'(q1_pdx_q[PW-1:NormBits]);
    tys   = q1_dsy_q ? -DotW'(q1_pdy_q[PW-1:NormBits]) : DotW'(q1_pdy_q[PW-1:NormBits]);
    dot_d = txs + tys;
    sepx  = q1_it_q.sx ? -34'(q1_psx_q[PW-1:NormBits+1]) : 34'(q1_psx_q[PW-1:NormBits+1]);
    sepy  = q1_it_q.sy ? -34'(q1_psy_q[PW-1:NormBits+1]) : 34'(q1_psy_q[PW-1:NormBits+1]);
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       np = 34'(signed'(q1_it_q.pos[i])) + sepx;
        1:       np = 34'(signed'(q1_it_q.pos[i])) + sepy;
        2:       np = 34'(signed'(q1_it_q.pos[i])) - sepx;
        default: np = 34'(signed'(q1_it_q.pos[i])) - sepy;
      endcase
      pos2_d[i] = q1_it_q.contact ? sat32(SatW'(np)) : q1_it_q.pos[i];
    end
    app_d = q1_it_q.contact && dot_d[DotW-1] && (q1_it_q.msum != '0);
  end

  logic [3:0][31:0]   q2_pos_q, q2_vel_q;
  logic [QuoBits-1:0] q2_nxm_q, q2_nym_q, q2_f1_q, q2_f2_q;
  logic [DotW-1:0]    q2_dot_q;
  logic               q2_sx_q, q2_sy_q, q2_app_q, q2_con_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_pos_q <= pos2_d;
      q2_vel_q <= q1_it_q.vel;
      q2_nxm_q <= q1_nxm_q;
      q2_nym_q <= q1_nym_q;
      q2_f1_q  <= q1_f1_q;
      q2_f2_q  <= q1_f2_q;
      q2_dot_q <= dot_d;
      q2_sx_q  <= q1_it_q.sx;
      q2_sy_q  <= q1_it_q.sy;
      q2_app_q <= app_d;
      q2_con_q <= q1_it_q.contact;
    end
  end

  // stage 3: dot times the mass weights
  logic [DotW-1:0] dot_neg;
  logic [DMW-1:0]  dm;
  logic [3:0][31:0]   q3_pos_q, q3_vel_q;
  logic [QuoBits-1:0] q3_nxm_q, q3_nym_q;
  logic [PrW-1:0]     q3_p1_q, q3_p2_q;
  logic               q3_dneg_q, q3_sx_q, q3_sy_q, q3_app_q, q3_con_q;

  assign dot_neg = -q2_dot_q;
  assign dm      = q2_dot_q[DotW-1] ? dot_neg[DMW-1:0] : q2_dot_q[DMW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q3_pos_q  <= q2_pos_q;
      q3_vel_q  <= q2_vel_q;
      q3_nxm_q  <= q2_nxm_q;
      q3_nym_q  <= q2_nym_q;
      q3_p1_q   <= PrW'(dm) * PrW'(q2_f2_q);
      q3_p2_q   <= PrW'(dm) * PrW'(q2_f1_q);
      q3_dneg_q <= q2_dot_q[DotW-1];
      q3_sx_q   <= q2_sx_q;
      q3_sy_q   <= q2_sy_q;
      q3_app_q  <= q2_app_q;
      q3_con_q  <= q2_con_q;
    end
  end

  // stage 4: doubled impulse times the normal
  logic [KW-1:0] k1m, k2m;
  logic [3:0][31:0]     q4_pos_q, q4_vel_q;
  logic [3:0][KnW-1:0]  q4_kn_q;
  logic                 q4_dneg_q, q4_sx_q, q4_sy_q, q4_app_q, q4_con_q;

  assign k1m = {q3_p1_q[PrW-1:NormBits], 1'b0};
  assign k2m = {q3_p2_q[PrW-1:NormBits], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q4_pos_q   <= q3_pos_q;
      q4_vel_q   <= q3_vel_q;
      q4_kn_q[0] <= KnW'(k1m) * KnW'(q3_nxm_q);
      q4_kn_q[1] <= KnW'(k1m) * KnW'(q3_nym_q);
      q4_kn_q[2] <= KnW'(k2m) * KnW'(q3_nxm_q);
      q4_kn_q[3] <= KnW'(k2m) * KnW'(q3_nym_q);
      q4_dneg_q  <= q3_dneg_q;
      q4_sx_q    <= q3_sx_q;
      q4_sy_q    <= q3_sy_q;
      q4_app_q   <= q3_app_q;
      q4_con_q   <= q3_con_q;
    end
  end

  // stage 5: velocity change, then magnitude for the friction product
  logic [3:0][UMW-1:0] um_d;
  logic [3:0]          us_d;

  always_comb begin
    logic               sn;
    logic signed [TW:0] ts;
    logic signed [UW-1:0] u;
    logic [UW-1:0]      un;
    sn = 1'b0;
    ts = '0;
    u  = '0;
    un = '0;
    for (int i = 0; i < 4; i++) begin
      sn = q4_dneg_q ^ ((i == 1 || i == 3) ? q4_sy_q : q4_sx_q);
      ts = sn ? -signed'({1'b0, q4_kn_q[i][KnW-1:NormBits]})
              : signed'({1'b0, q4_kn_q[i][KnW-1:NormBits]});
      if (i < 2) begin
        u = UW'(signed'(q4_vel_q[i])) - UW'(ts);
      end else begin
        u = UW'(signed'(q4_vel_q[i])) + UW'(ts);
      end
      un      = -u;
      us_d[i] = u[UW-1];
      um_d[i] = u[UW-1] ? un[UMW-1:0] : u[UMW-1:0];
    end
  end

  logic [3:0][31:0]    q5_pos_q, q5_vel_q;
  logic [3:0][UMW-1:0] q5_um_q;
  logic [3:0]          q5_us_q;
  logic                q5_app_q, q5_con_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q5_pos_q <= q4_pos_q;
      q5_vel_q <= q4_vel_q;
      q5_um_q  <= um_d;
      q5_us_q  <= us_d;
      q5_app_q <= q4_app_q;
      q5_con_q <= q4_con_q;
    end
  end

  // stage 6: friction scale
  logic [3:0][31:0]    q6_pos_q, q6_vel_q;
  logic [3:0][UGW-1:0] q6_ug_q;
  logic [3:0]          q6_us_q;
  logic                q6_app_q, q6_con_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q6_pos_q <= q5_pos_q;
      q6_vel_q <= q5_vel_q;
      for (int i = 0; i < 4; i++) begin
        q6_ug_q[i] <= UGW'(q5_um_q[i]) * UGW'(gain_i);
      end
      q6_us_q  <= q5_us_q;
      q6_app_q <= q5_app_q;
      q6_con_q <= q5_con_q;
    end
  end

  // stage 7: shift, sign, saturate, select into the output register
  logic [3:0][31:0] vel7_d;

  always_comb begin
    logic signed [UGW-FRAC_BITS:0] ws;
    ws = '0;
    for (int i = 0; i < 4; i++) begin
      ws = q6_us_q[i] ? -signed'({1'b0, q6_ug_q[i][UGW-1:FRAC_BITS]})
                      : signed'({1'b0, q6_ug_q[i][UGW-1:FRAC_BITS]});
      vel7_d[i] = q6_app_q ? sat32(SatW'(ws)) : q6_vel_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_o     <= q6_pos_q;
      vel_o     <= vel7_d;
      overlap_o <= q6_con_q;
      impulse_o <= q6_app_q;
    end
  end

endmodule

`default_nettype wire

[rtl/disc_pair_collision_response.sv]
// throughput: one disc pair per cycle while the output is not stalled; the square root and
// the dividers resolve two bits per stage, which sets the pipeline depth
// a stalled valid output freezes the whole pipeline, input stall follows at once
// reset clears all valid bits and sets the friction gain to 1.0
`default_nettype none

module disc_pair_collision_response import dpcr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FRAC_BITS:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] first_pos_x_i,
  input  logic signed [31:0] first_pos_y_i,
  input  logic signed [31:0] first_vel_x_i,
  input  logic signed [31:0] first_vel_y_i,
  input  logic [30:0]        first_radius_i,
  input  logic [31:0]        first_mass_i,
  input  logic signed [31:0] second_pos_x_i,
  input  logic signed [31:0] second_pos_y_i,
  input  logic signed [31:0] second_vel_x_i,
  input  logic signed [31:0] second_vel_y_i,
  input  logic [30:0]        second_radius_i,
  input  logic [31:0]        second_mass_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_first_pos_x_o,
  output logic signed [31:0] new_first_pos_y_o,
  output logic signed [31:0] new_first_vel_x_o,
  output logic signed [31:0] new_first_vel_y_o,
  output logic signed [31:0] new_second_pos_x_o,
  output logic signed [31:0] new_second_pos_y_o,
  output logic signed [31:0] new_second_vel_x_o,
  output logic signed [31:0] new_second_vel_y_o,
  output logic               overlapping_o,
  output logic               impulse_applied_o
);

  logic [FRAC_BITS:0] gain_q;
  logic [Latency-1:0] vld_q;
  logic               en;

  assign en          = !vld_q[Latency-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[Latency-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= {1'b1, {FRAC_BITS{1'b0}}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  // stage 1: differences, sums, magnitudes
  item_t s1_d, s1_q;

  always_comb begin
    logic signed [32:0] dx, dy, dxn, dyn;
    dx  = 33'(first_pos_x_i) - 33'(second_pos_x_i);
    dy  = 33'(first_pos_y_i) - 33'(second_pos_y_i);
    dxn = -dx;
    dyn = -dy;
    s1_d.pos[0] = first_pos_x_i;
    s1_d.pos[1] = first_pos_y_i;
    s1_d.pos[2] = second_pos_x_i;
    s1_d.pos[3] = second_pos_y_i;
    s1_d.vel[0] = first_vel_x_i;
    s1_d.vel[1] = first_vel_y_i;
    s1_d.vel[2] = second_vel_x_i;
    s1_d.vel[3] = second_vel_y_i;
    s1_d.rvx     = 33'(first_vel_x_i) - 33'(second_vel_x_i);
    s1_d.rvy     = 33'(first_vel_y_i) - 33'(second_vel_y_i);
    s1_d.rsum    = 32'(first_radius_i) + 32'(second_radius_i);
    s1_d.m1      = first_mass_i;
    s1_d.m2      = second_mass_i;
    s1_d.msum    = 33'(first_mass_i) + 33'(second_mass_i);
    s1_d.ax      = dx[32] ? dxn[31:0] : dx[31:0];
    s1_d.ay      = dy[32] ? dyn[31:0] : dy[31:0];
    s1_d.sx      = dx[32];
    s1_d.sy      = dy[32];
    s1_d.contact = 1'b0;
    s1_d.ovl     = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: squares
  item_t       s2_q;
  logic [63:0] sqx_q, sqy_q, rr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s1_q;
      sqx_q <= 64'(s1_q.ax) * 64'(s1_q.ax);
      sqy_q <= 64'(s1_q.ay) * 64'(s1_q.ay);
      rr_q  <= 64'(s1_q.rsum) * 64'(s1_q.rsum);
    end
  end

  // stage 3: exact contact test on the squared distance
  item_t       s3_d, s3_q;
  logic [64:0] d2;
  logic [63:0] d2_q;

  always_comb begin
    d2           = 65'(sqx_q) + 65'(sqy_q);
    s3_d         = s2_q;
    s3_d.contact = !d2[64] && (d2[63:0] != '0) && (d2[63:0] < rr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
      d2_q <= d2[63:0];
    end
  end

  // square root, item rides alongside
  logic [RootW-1:0] dist_root;
  item_t            sq_dly_q [SqrtStages];

  dpcr_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (d2_q),
    .root_o (dist_root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_dly_q[0] <= s3_q;
      for (int i = 1; i < SqrtStages; i++) begin
        sq_dly_q[i] <= sq_dly_q[i-1];
      end
    end
  end

  // dividers: unit normal and mass weights
  item_t              dv_in;
  item_t              dv_dly_q [DivStages];
  logic [QuoBits-1:0] nxm, nym, f1, f2;

  always_comb begin
    dv_in     = sq_dly_q[SqrtStages-1];
    dv_in.ovl = dv_in.rsum - dist_root;
  end

  dpcr_div #(.DW(32)) u_div_nx (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  ({1'b0, dv_in.ax[31:1]}),
    .nbit_i (dv_in.ax[0]),
    .den_i  (dist_root),
    .quo_o  (nxm)
  );

  dpcr_div #(.DW(32)) u_div_ny (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  ({1'b0, dv_in.ay[31:1]}),
    .nbit_i (dv_in.ay[0]),
    .den_i  (dist_root),
    .quo_o  (nym)
  );

  dpcr_div #(.DW(33)) u_div_f1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  ({2'b00, dv_in.m1[31:1]}),
    .nbit_i (dv_in.m1[0]),
    .den_i  (dv_in.msum),
    .quo_o  (f1)
  );

  dpcr_div #(.DW(33)) u_div_f2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rem_i  ({2'b00, dv_in.m2[31:1]}),
    .nbit_i (dv_in.m2[0]),
    .den_i  (dv_in.msum),
    .quo_o  (f2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_dly_q[0] <= dv_in;
      for (int i = 1; i < DivStages; i++) begin
        dv_dly_q[i] <= dv_dly_q[i-1];
      end
    end
  end

  // back end
  logic [3:0][31:0] pos_out, vel_out;

  dpcr_impulse #(.FRAC_BITS(FRAC_BITS)) u_imp (
    .clk_i     (clk_i),
    .en_i      (en),
    .item_i    (dv_dly_q[DivStages-1]),
    .nxm_i     (nxm),
    .nym_i     (nym),
    .f1_i      (f1),
    .f2_i      (f2),
    .gain_i    (gain_q),
    .pos_o     (pos_out),
    .vel_o     (vel_out),
    .overlap_o (overlapping_o),
    .impulse_o (impulse_applied_o)
  );

  assign new_first_pos_x_o  = pos_out[0];
  assign new_first_pos_y_o  = pos_out[1];
  assign new_second_pos_x_o = pos_out[2];
  assign new_second_pos_y_o = pos_out[3];
  assign new_first_vel_x_o  = vel_out[0];
  assign new_first_vel_y_o  = vel_out[1];
  assign new_second_vel_x_o = vel_out[2];
  assign new_second_vel_y_o = vel_out[3];

endmodule

`default_nettype wire

[rtl/dpcr_checker.sv]
// port-level checks for the disc pair collision response, bound to the top level
// depends on disc_pair_collision_response_macros.svh
`default_nettype none
`include "disc_pair_collision_response_macros.svh"

module dpcr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] new_first_pos_x_o,
  input logic signed [31:0] new_first_pos_y_o,
  input logic signed [31:0] new_first_vel_x_o,
  input logic signed [31:0] new_first_vel_y_o,
  input logic signed [31:0] new_second_pos_x_o,
  input logic signed [31:0] new_second_pos_y_o,
  input logic signed [31:0] new_second_vel_x_o,
  input logic signed [31:0] new_second_vel_y_o,
  input logic               overlapping_o,
  input logic               impulse_applied_o
);

  // stalled result beat holds
  `DPCR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(new_first_pos_x_o) && $stable(new_first_pos_y_o) && $stable(new_first_vel_x_o) && $stable(new_first_vel_y_o) && $stable(new_second_pos_x_o) && $stable(new_second_pos_y_o) && $stable(new_second_vel_x_o) && $stable(new_second_vel_y_o) && $stable(overlapping_o) && $stable(impulse_applied_o), "stalled result changed")

  `DPCR_ASSERT(a_imp_ovl, clk_i, rst_ni, out_valid_o |-> !impulse_applied_o || overlapping_o, "impulse without overlap")

  // input only stalls behind a blocked result
  `DPCR_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free output")

  `DPCR_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "pipeline busy in reset")

endmodule

bind disc_pair_collision_response dpcr_checker u_dpcr_checker (.*);

`default_nettype wire
